// ----- hdl/dfh_pkg.sv -----
// Package for the deduplicating pair queue: sizes, operation codes, helpers.
package dfh_pkg;

  localparam int unsigned MaxEntries = 256;
  localparam int unsigned PosW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);
  localparam int unsigned CoordW     = 32;
  localparam int unsigned PairW      = 2 * CoordW;

  typedef enum logic [1:0] {
    KIND_PUSH     = 2'd0,
    KIND_POP      = 2'd1,
    KIND_CONTAINS = 2'd2,
    KIND_CLEAR    = 2'd3
  } kind_e;

  // Clamp a written capacity to one through MaxEntries.
  function automatic logic [CntW-1:0] clamp_cap(input logic [8:0] v);
    logic [CntW-1:0] r;
    if (v == 9'd0) begin
      r = CntW'(1);
    end else if (32'(v) > MaxEntries) begin
      r = CntW'(MaxEntries);
    end else begin
      r = CntW'(v);
    end
    return r;
  endfunction

endpackage

// ----- hdl/dfh_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dfh_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ----- hdl/dedup_fifo_hashed.sv -----
// Top level of the deduplicating queue of signed coordinate pairs.
// Usage: drive kind_i, coord_x_i, coord_z_i and raise start_i; the word is
// taken at a clock edge with start_i high, busy_o and cfg_we_i low. busy_o
// stays high while the operation runs. The result word (ok_o, out_x_o, out_z_o,
// overflow_o, occupancy_o) shows for exactly one cycle with done_o high; the
// receiver cannot stall it, so it must sample in that cycle.
// Steps from the accepting edge to done_o:
//   push, contains: one shared 64-bit compare unit walks the queued pairs,
//                   one ring read per cycle, then settles the last compare;
//                   an empty queue has nothing to walk
//   pop: one ring read; clear, or pop on empty: done_o in the next cycle
// A hit stops the walk there.
// cfg_we_i with cfg_wdata_i writes the capacity (zero taken as one, above
// 256 taken as 256); this empties the queue and clears overflow. Write it
// only while idle.
// Reset (rst_ni low, asynchronous) empties the queue, clears overflow and
// sets capacity to 256; no clearing pass is needed.
module dedup_fifo_hashed (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [1:0]                 kind_i,
  input  logic signed [31:0]         coord_x_i,
  input  logic signed [31:0]         coord_z_i,
  input  logic                       cfg_we_i,
  input  logic [8:0]                 cfg_wdata_i,
  output logic                       done_o,
  output logic                       ok_o,
  output logic signed [31:0]         out_x_o,
  output logic signed [31:0]         out_z_o,
  output logic                       overflow_o,
  output logic [8:0]                 occupancy_o
);
  import dfh_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_POP
  } state_e;

  state_e             state_q;
  kind_e              kind_q;
  logic [CoordW-1:0]  x_q, z_q;
  logic [CntW-1:0]    cap_q, live_q, issued_q;
  logic [PosW-1:0]    head_q, ptr_q;
  logic               ovf_q, rd_vld_q, found_q;
  logic               done_q, ok_q;
  logic [CoordW-1:0]  ox_q, oz_q;

  logic               re;
  logic [PosW-1:0]    raddr;
  logic               we;
  logic [PosW-1:0]    waddr;
  logic [PairW-1:0]   rdata;
  logic               hit, scan_end, issue;
  logic [CntW:0]      tail_sum;
  logic [CntW-1:0]    tail;
  logic [PosW-1:0]    head_nx, ptr_nx;

  dfh_ram #(.Width(PairW), .Depth(MaxEntries)) u_ring (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({x_q, z_q}),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign issue    = (state_q == S_SCAN) && (issued_q != live_q) && !found_q && !hit;
  assign hit      = rd_vld_q && (rdata == {x_q, z_q});
  assign scan_end = (state_q == S_SCAN) &&
                    (hit || found_q || ((issued_q == live_q) && !rd_vld_q));

  // Tail position: head plus occupancy, wrapped once.
  assign tail_sum = {1'b0, CntW'(head_q)} + {1'b0, live_q};
  assign tail     = (tail_sum >= {1'b0, cap_q}) ? CntW'(tail_sum - {1'b0, cap_q})
                                                : CntW'(tail_sum);
  assign head_nx  = (CntW'(head_q) + CntW'(1) == cap_q) ? '0 : head_q + PosW'(1);
  assign ptr_nx   = (CntW'(ptr_q) + CntW'(1) == cap_q) ? '0 : ptr_q + PosW'(1);

  always_comb begin
    re    = 1'b0;
    raddr = ptr_q;
    if (state_q == S_IDLE && start_i && kind_e'(kind_i) == KIND_POP) begin
      re    = live_q != '0;
      raddr = head_q;
    end else if (issue) begin
      re = 1'b1;
    end
  end

  assign we    = scan_end && kind_q == KIND_PUSH && !(hit || found_q) && (live_q < cap_q);
  assign waddr = tail[PosW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cap_q    <= CntW'(MaxEntries);
      live_q   <= '0;
      issued_q <= '0;
      head_q   <= '0;
      ptr_q    <= '0;
      ovf_q    <= 1'b0;
      rd_vld_q <= 1'b0;
      found_q  <= 1'b0;
      done_q   <= 1'b0;
      ok_q     <= 1'b0;
      kind_q   <= KIND_PUSH;
      ox_q     <= '0;
      oz_q     <= '0;
      x_q      <= '0;
      z_q      <= '0;
    end else begin
      done_q   <= 1'b0;
      rd_vld_q <= issue;
      case (state_q)
        S_IDLE: begin
          if (cfg_we_i) begin
            cap_q  <= clamp_cap(cfg_wdata_i);
            live_q <= '0;
            head_q <= '0;
            ovf_q  <= 1'b0;
          end else if (start_i) begin
            kind_q   <= kind_e'(kind_i);
            x_q      <= coord_x_i;
            z_q      <= coord_z_i;
            ptr_q    <= head_q;
            issued_q <= '0;
            found_q  <= 1'b0;
            ox_q     <= '0;
            oz_q     <= '0;
            ok_q     <= 1'b0;
            case (kind_e'(kind_i))
              KIND_PUSH, KIND_CONTAINS: state_q <= S_SCAN;
              KIND_POP: begin
                if (live_q != '0) begin
                  state_q <= S_POP;
                end else begin
                  done_q <= 1'b1;
                end
              end
              KIND_CLEAR: begin
                live_q <= '0;
                head_q <= '0;
                done_q <= 1'b1;
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
        S_SCAN: begin
          if (issue) begin
            issued_q <= issued_q + CntW'(1);
            ptr_q    <= ptr_nx;
          end
          if (hit) begin
            found_q <= 1'b1;
          end
          if (scan_end) begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
            if (kind_q == KIND_CONTAINS) begin
              ok_q <= hit || found_q;
            end else if (!(hit || found_q)) begin
              if (live_q >= cap_q) begin
                ovf_q <= 1'b1;
              end else begin
                live_q <= live_q + CntW'(1);
                ok_q   <= 1'b1;
              end
            end
          end
        end
        S_POP: begin
          ox_q    <= rdata[PairW-1:CoordW];
          oz_q    <= rdata[CoordW-1:0];
          ok_q    <= 1'b1;
          head_q  <= head_nx;
          live_q  <= live_q - CntW'(1);
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o      = state_q != S_IDLE;
  assign done_o      = done_q;
  assign ok_o        = ok_q;
  assign out_x_o     = ox_q;
  assign out_z_o     = oz_q;
  assign overflow_o  = ovf_q;
  assign occupancy_o = 9'(live_q);

`ifndef SYNTHESIS
  a_live_le_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= cap_q) else $error("occupancy above capacity");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result shown while busy");
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !cfg_we_i && kind_i == KIND_CLEAR)
      |=> (done_o && occupancy_o == 9'd0)) else $error("clear left entries");
  a_write_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (CntW'(waddr) < cap_q)) else $error("ring write beyond capacity");
`endif

endmodule
